// ----- src/mtq_pkg.sv -----
// Shared constants and types for the multi-timer queue.
package mtq_pkg;

  localparam int TIMER_SLOTS_DEF = 64;
  localparam int TIME_BITS_DEF   = 48;
  localparam int FIRE_LIMIT      = 64;

  localparam logic [23:0] MIN_INTERVAL_RST = 24'd50;
  localparam logic [23:0] MAX_INTERVAL_RST = 24'd10000;
  localparam logic [23:0] DELAY_MAX        = 24'hFFFFFF;
  localparam logic [24:0] DELAY_NONE       = 25'h1FFFFFF;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_RESET  = 2'd2;
  localparam logic [1:0] CMD_TICK   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam logic [1:0] CFG_MIN = 2'd0;
  localparam logic [1:0] CFG_MAX = 2'd1;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] id;
    logic       fired;
  } res_t;

endpackage

// ----- src/multi_timer_queue.sv -----
// Top level of the multi-timer queue: sorted timer list in block RAMs.
//
// Up to TIMER_SLOTS timers live in a slot RAM (interval, repeat limit, fire
// count, due time) indexed by id, and an order RAM holds the ids sorted by due
// time (ties keep insertion order). One request is worked on at a time; the
// block takes the next request once the previous one has been reduced to
// results. Every RAM has a registered read, so the cost is set by walks over
// the order RAM: an add scans up to TIMER_SLOTS valid bits for the lowest free
// id (one a cycle) and then inserts from the tail, through S_INS, S_INS_W1 and
// S_INS_W2 per entry moved; remove/reset scan the order list through S_RM_RD and
// S_RM_CK per entry; a tick pays a head read, a full list shift and an insert
// for each firing, up to 64 firings. All results of a request are buffered in a
// 64-entry result RAM and delivered afterwards, because next_delay,
// target_exists and active_count describe the state after the whole request;
// each result passes through S_LOAD and S_PRES and may be held by a stall on
// out_ready. Configuration writes are accepted at any time (cfg_ready is always
// high) but are meant for idle periods.
module multi_timer_queue #(
  parameter int TIMER_SLOTS = mtq_pkg::TIMER_SLOTS_DEF,
  parameter int TIME_BITS   = mtq_pkg::TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [23:0] in_interval_ms,
  input  logic [15:0] in_repeat_count,
  input  logic [5:0]  in_timer_id,
  input  logic [47:0] in_now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [5:0]  out_result_id,
  output logic        out_fired,
  output logic        out_last,
  output logic signed [24:0] out_next_delay,
  output logic        out_target_exists,
  output logic [6:0]  out_active_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int TB = TIME_BITS;
  localparam int IW = $clog2(TIMER_SLOTS);
  localparam int CW = $clog2(TIMER_SLOTS + 1);
  localparam int FW = $clog2(mtq_pkg::FIRE_LIMIT);
  localparam int NW = $clog2(mtq_pkg::FIRE_LIMIT + 1);

  typedef struct packed {
    logic [23:0]   interval;
    logic [15:0]   rep_limit;
    logic [15:0]   fire_cnt;
    logic [TB-1:0] due;
  } slot_t;

  // sequencer states
  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_FREE    = 5'd1;
  localparam logic [4:0] S_INS     = 5'd2;
  localparam logic [4:0] S_INS_W1  = 5'd3;
  localparam logic [4:0] S_INS_W2  = 5'd4;
  localparam logic [4:0] S_RM_RD   = 5'd5;
  localparam logic [4:0] S_RM_CK   = 5'd6;
  localparam logic [4:0] S_RS      = 5'd7;
  localparam logic [4:0] S_TK_HEAD = 5'd8;
  localparam logic [4:0] S_TK_H1   = 5'd9;
  localparam logic [4:0] S_TK_H2   = 5'd10;
  localparam logic [4:0] S_TK_UPD  = 5'd11;
  localparam logic [4:0] S_TK_END  = 5'd12;
  localparam logic [4:0] S_SUM     = 5'd13;
  localparam logic [4:0] S_SUM1    = 5'd14;
  localparam logic [4:0] S_SUM2    = 5'd15;
  localparam logic [4:0] S_SUM3    = 5'd16;
  localparam logic [4:0] S_LOAD    = 5'd17;
  localparam logic [4:0] S_PRES    = 5'd18;

  // memories: slot data by id, sorted id list, per-request result buffer
  slot_t          slot_mem [TIMER_SLOTS];
  logic [IW-1:0]  ord_mem  [TIMER_SLOTS];
  mtq_pkg::res_t  rb_mem   [mtq_pkg::FIRE_LIMIT];

  slot_t          slot_q;
  logic [IW-1:0]  ord_q;
  mtq_pkg::res_t  rb_q;

  logic [IW-1:0]  slot_ra, ord_ra;
  logic           slot_we, ord_we, rb_we;
  logic [IW-1:0]  slot_wa, ord_wa;
  logic [FW-1:0]  rb_wa;
  slot_t          slot_wd;
  logic [IW-1:0]  ord_wd;
  mtq_pkg::res_t  rb_wd;

  logic [4:0]        state_r, state_nxt;
  logic [23:0]       min_r, max_r;
  logic [TIMER_SLOTS-1:0] valid_r, valid_nxt;
  logic [CW-1:0]     len_r, len_nxt;
  logic [CW-1:0]     k_r, k_nxt;
  logic [1:0]        cmd_r, cmd_nxt;
  logic [23:0]       ival_r, ival_nxt;
  logic [15:0]       rep_r, rep_nxt;
  logic [5:0]        tid_r, tid_nxt;
  logic [TB-1:0]     now_r, now_nxt;
  logic [IW-1:0]     cur_id_r, cur_id_nxt;
  logic [IW-1:0]     tmp_id_r, tmp_id_nxt;
  logic [IW-1:0]     rm_id_r, rm_id_nxt;
  logic              found_r, found_nxt;
  slot_t             cur_r, cur_nxt;
  logic [NW-1:0]     n_r, n_nxt;
  logic [NW-1:0]     rd_r, rd_nxt;
  logic [TB:0]       diff_r, diff_nxt;
  logic [24:0]       nd_r, nd_nxt;
  logic              ex_r, ex_nxt;
  logic              ov_r, ov_nxt;
  mtq_pkg::res_t     ores_r, ores_nxt;
  logic              olast_r, olast_nxt;
  logic [24:0]       ond_r, ond_nxt;
  logic              oex_r, oex_nxt;
  logic [6:0]        ocnt_r, ocnt_nxt;

  logic [63:0]       now_wide;
  logic [TB-1:0]     now_in;
  logic [23:0]       ival_cl;
  logic [TB:0]       sum_now, sum_due;
  logic [15:0]       fc_inc;
  logic              tid_live;

  assign now_wide = {16'd0, in_now_ms};
  assign now_in   = now_wide[TB-1:0];

  // clamp: min is tested first
  always_comb begin
    ival_cl = in_interval_ms;
    if (in_interval_ms < min_r) begin
      ival_cl = min_r;
    end else if (in_interval_ms > max_r) begin
      ival_cl = max_r;
    end
  end

  // now + interval (add uses the latched interval, reset the stored one)
  assign sum_now = {1'b0, now_r} +
                   (TB + 1)'((cmd_r == mtq_pkg::CMD_ADD) ? ival_r : slot_q.interval);
  assign sum_due = {1'b0, cur_r.due} + (TB + 1)'(cur_r.interval);
  assign fc_inc  = (cur_r.fire_cnt == 16'hFFFF) ? cur_r.fire_cnt : cur_r.fire_cnt + 16'd1;
  assign tid_live = (32'(tid_r) < TIMER_SLOTS) && valid_r[tid_r[IW-1:0]];

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt  = state_r;
    valid_nxt  = valid_r;
    len_nxt    = len_r;
    k_nxt      = k_r;
    cmd_nxt    = cmd_r;
    ival_nxt   = ival_r;
    rep_nxt    = rep_r;
    tid_nxt    = tid_r;
    now_nxt    = now_r;
    cur_id_nxt = cur_id_r;
    tmp_id_nxt = tmp_id_r;
    rm_id_nxt  = rm_id_r;
    found_nxt  = found_r;
    cur_nxt    = cur_r;
    n_nxt      = n_r;
    rd_nxt     = rd_r;
    diff_nxt   = diff_r;
    nd_nxt     = nd_r;
    ex_nxt     = ex_r;
    ov_nxt     = ov_r;
    ores_nxt   = ores_r;
    olast_nxt  = olast_r;
    ond_nxt    = ond_r;
    oex_nxt    = oex_r;
    ocnt_nxt   = ocnt_r;

    slot_ra = '0;
    ord_ra  = '0;
    slot_we = 1'b0;
    slot_wa = cur_id_r;
    slot_wd = cur_r;
    ord_we  = 1'b0;
    ord_wa  = k_r[IW-1:0];
    ord_wd  = cur_id_r;
    rb_we   = 1'b0;
    rb_wa   = n_r[FW-1:0];
    rb_wd   = '0;

    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_cmd;
          ival_nxt  = ival_cl;
          rep_nxt   = in_repeat_count;
          tid_nxt   = in_timer_id;
          now_nxt   = now_in;
          n_nxt     = '0;
          k_nxt     = '0;
          found_nxt = 1'b0;
          unique case (in_cmd)
            mtq_pkg::CMD_ADD:  state_nxt = S_FREE;
            mtq_pkg::CMD_TICK: state_nxt = S_TK_HEAD;
            default: begin
              rm_id_nxt = in_timer_id[IW-1:0];
              if ((32'(in_timer_id) < TIMER_SLOTS) && valid_r[in_timer_id[IW-1:0]]) begin
                state_nxt = S_RM_RD;
              end else begin
                // first result of the new request
                rb_we     = 1'b1;
                rb_wa     = '0;
                rb_wd     = '{mtq_pkg::ST_NOTFOUND, 6'd0, 1'b0};
                n_nxt     = NW'(1);
                state_nxt = S_SUM;
              end
            end
          endcase
        end
      end

      // lowest free id, one valid bit a cycle
      S_FREE: begin
        if (32'(k_r) == TIMER_SLOTS) begin
          rb_we     = 1'b1;
          rb_wd     = '{mtq_pkg::ST_NOTFOUND, 6'd0, 1'b0};
          n_nxt     = n_r + NW'(1);
          state_nxt = S_SUM;
        end else if (!valid_r[k_r[IW-1:0]]) begin
          n_nxt = n_r + NW'(1);
          rb_we = 1'b1;
          if (sum_now[TB]) begin
            rb_wd     = '{mtq_pkg::ST_OVERFLOW, 6'd0, 1'b0};
            state_nxt = S_SUM;
          end else begin
            rb_wd      = '{mtq_pkg::ST_OK, 6'(k_r), 1'b0};
            cur_id_nxt = k_r[IW-1:0];
            cur_nxt    = '{ival_r, rep_r, 16'd0, sum_now[TB-1:0]};
            slot_we    = 1'b1;
            slot_wa    = k_r[IW-1:0];
            slot_wd    = '{ival_r, rep_r, 16'd0, sum_now[TB-1:0]};
            k_nxt      = len_r;
            state_nxt  = S_INS;
          end
        end else begin
          k_nxt = k_r + CW'(1);
        end
      end

      // insert from the tail: move entries up while their due is later
      S_INS: begin
        if (k_r == '0) begin
          ord_we    = 1'b1;
          ord_wa    = '0;
          ord_wd    = cur_id_r;
          len_nxt   = len_r + CW'(1);
          valid_nxt[cur_id_r] = 1'b1;
          state_nxt = (cmd_r == mtq_pkg::CMD_TICK) ? S_TK_HEAD : S_SUM;
        end else begin
          ord_ra    = IW'(k_r - CW'(1));
          state_nxt = S_INS_W1;
        end
      end

      S_INS_W1: begin
        tmp_id_nxt = ord_q;
        slot_ra    = ord_q;
        state_nxt  = S_INS_W2;
      end

      S_INS_W2: begin
        ord_we = 1'b1;
        ord_wa = k_r[IW-1:0];
        if (slot_q.due > cur_r.due) begin
          ord_wd    = tmp_id_r;
          k_nxt     = k_r - CW'(1);
          state_nxt = S_INS;
        end else begin
          ord_wd    = cur_id_r;
          len_nxt   = len_r + CW'(1);
          valid_nxt[cur_id_r] = 1'b1;
          state_nxt = (cmd_r == mtq_pkg::CMD_TICK) ? S_TK_HEAD : S_SUM;
        end
      end

      // remove by id: find it, then shift the rest down in the same pass
      S_RM_RD: begin
        ord_ra    = k_r[IW-1:0];
        state_nxt = S_RM_CK;
      end

      S_RM_CK: begin
        if (found_r) begin
          ord_we = 1'b1;
          ord_wa = IW'(k_r - CW'(1));
          ord_wd = ord_q;
        end else if (ord_q == rm_id_r) begin
          found_nxt = 1'b1;
        end
        k_nxt = k_r + CW'(1);
        if (k_r + CW'(1) == len_r) begin
          len_nxt            = len_r - CW'(1);
          valid_nxt[rm_id_r] = 1'b0;
          unique case (cmd_r)
            mtq_pkg::CMD_REMOVE: begin
              rb_we     = 1'b1;
              rb_wd     = '{mtq_pkg::ST_OK, 6'd0, 1'b0};
              n_nxt     = n_r + NW'(1);
              state_nxt = S_SUM;
            end
            mtq_pkg::CMD_RESET: begin
              slot_ra   = rm_id_r;
              state_nxt = S_RS;
            end
            default: state_nxt = S_TK_UPD;
          endcase
        end else begin
          state_nxt = S_RM_RD;
        end
      end

      // reset: reschedule from now with the stored interval
      S_RS: begin
        rb_we = 1'b1;
        n_nxt = n_r + NW'(1);
        if (sum_now[TB]) begin
          rb_wd     = '{mtq_pkg::ST_OVERFLOW, 6'd0, 1'b0};
          state_nxt = S_SUM;
        end else begin
          rb_wd      = '{mtq_pkg::ST_OK, 6'd0, 1'b0};
          cur_id_nxt = rm_id_r;
          cur_nxt    = '{slot_q.interval, slot_q.rep_limit, 16'd0, sum_now[TB-1:0]};
          slot_we    = 1'b1;
          slot_wa    = rm_id_r;
          slot_wd    = '{slot_q.interval, slot_q.rep_limit, 16'd0, sum_now[TB-1:0]};
          k_nxt      = len_r;
          state_nxt  = S_INS;
        end
      end

      S_TK_HEAD: begin
        if ((32'(n_r) == mtq_pkg::FIRE_LIMIT) || (len_r == '0)) begin
          state_nxt = S_TK_END;
        end else begin
          ord_ra    = '0;
          state_nxt = S_TK_H1;
        end
      end

      S_TK_H1: begin
        cur_id_nxt = ord_q;
        slot_ra    = ord_q;
        state_nxt  = S_TK_H2;
      end

      S_TK_H2: begin
        cur_nxt = slot_q;
        if (slot_q.due > now_r) begin
          state_nxt = S_TK_END;
        end else begin
          rm_id_nxt = cur_id_r;
          k_nxt     = '0;
          found_nxt = 1'b0;
          state_nxt = S_RM_RD;
        end
      end

      S_TK_UPD: begin
        rb_we = 1'b1;
        n_nxt = n_r + NW'(1);
        if ((cur_r.rep_limit != 16'd0) && (fc_inc >= cur_r.rep_limit)) begin
          // last permitted firing: the timer stays removed
          rb_wd     = '{mtq_pkg::ST_OK, 6'(cur_id_r), 1'b1};
          state_nxt = S_TK_HEAD;
        end else if (sum_due[TB]) begin
          rb_wd     = '{mtq_pkg::ST_OVERFLOW, 6'(cur_id_r), 1'b0};
          state_nxt = S_TK_END;
        end else begin
          rb_wd     = '{mtq_pkg::ST_OK, 6'(cur_id_r), 1'b1};
          cur_nxt   = '{cur_r.interval, cur_r.rep_limit, fc_inc, sum_due[TB-1:0]};
          slot_we   = 1'b1;
          slot_wa   = cur_id_r;
          slot_wd   = '{cur_r.interval, cur_r.rep_limit, fc_inc, sum_due[TB-1:0]};
          k_nxt     = len_r;
          state_nxt = S_INS;
        end
      end

      S_TK_END: begin
        if (n_r == '0) begin
          rb_we = 1'b1;
          rb_wd = '{mtq_pkg::ST_OK, 6'd0, 1'b0};
          n_nxt = NW'(1);
        end
        state_nxt = S_SUM;
      end

      // summary fields shared by all results of the request
      S_SUM: begin
        ex_nxt = tid_live;
        rd_nxt = '0;
        if (len_r == '0) begin
          nd_nxt    = mtq_pkg::DELAY_NONE;
          state_nxt = S_LOAD;
        end else begin
          ord_ra    = '0;
          state_nxt = S_SUM1;
        end
      end

      S_SUM1: begin
        slot_ra   = ord_q;
        state_nxt = S_SUM2;
      end

      S_SUM2: begin
        diff_nxt  = {1'b0, slot_q.due} - {1'b0, now_r};
        state_nxt = S_SUM3;
      end

      S_SUM3: begin
        if (diff_r[TB] || (diff_r == '0)) begin
          nd_nxt = '0;
        end else if (diff_r[TB-1:0] > TB'(mtq_pkg::DELAY_MAX)) begin
          nd_nxt = {1'b0, mtq_pkg::DELAY_MAX};
        end else begin
          nd_nxt = 25'(diff_r[TB-1:0]);
        end
        state_nxt = S_LOAD;
      end

      S_LOAD: state_nxt = S_PRES;

      // output register: load when empty or being drained
      S_PRES: begin
        if (!ov_r || out_ready) begin
          ov_nxt    = 1'b1;
          ores_nxt  = rb_q;
          olast_nxt = (rd_r + NW'(1) == n_r);
          ond_nxt   = nd_r;
          oex_nxt   = ex_r;
          ocnt_nxt  = 7'(len_r);
          if (rd_r + NW'(1) == n_r) begin
            state_nxt = S_IDLE;
          end else begin
            rd_nxt    = rd_r + NW'(1);
            state_nxt = S_LOAD;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // RAMs: one write and one registered read each
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    slot_q <= slot_mem[slot_ra];
    if (ord_we) begin
      ord_mem[ord_wa] <= ord_wd;
    end
    ord_q <= ord_mem[ord_ra];
    if (rb_we) begin
      rb_mem[rb_wa] <= rb_wd;
    end
    rb_q <= rb_mem[rd_r[FW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      len_r   <= '0;
      ov_r    <= 1'b0;
      min_r   <= mtq_pkg::MIN_INTERVAL_RST;
      max_r   <= mtq_pkg::MAX_INTERVAL_RST;
      n_r     <= '0;
      rd_r    <= '0;
      k_r     <= '0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      len_r   <= len_nxt;
      ov_r    <= ov_nxt;
      n_r     <= n_nxt;
      rd_r    <= rd_nxt;
      k_r     <= k_nxt;
      found_r <= found_nxt;
      if (cfg_valid) begin
        if (cfg_index == mtq_pkg::CFG_MIN) begin
          min_r <= cfg_data;
        end else if (cfg_index == mtq_pkg::CFG_MAX) begin
          max_r <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    ival_r   <= ival_nxt;
    rep_r    <= rep_nxt;
    tid_r    <= tid_nxt;
    now_r    <= now_nxt;
    cur_id_r <= cur_id_nxt;
    tmp_id_r <= tmp_id_nxt;
    rm_id_r  <= rm_id_nxt;
    cur_r    <= cur_nxt;
    diff_r   <= diff_nxt;
    nd_r     <= nd_nxt;
    ex_r     <= ex_nxt;
    ores_r   <= ores_nxt;
    olast_r  <= olast_nxt;
    ond_r    <= ond_nxt;
    oex_r    <= oex_nxt;
    ocnt_r   <= ocnt_nxt;
  end

  assign out_valid         = ov_r;
  assign out_status        = ores_r.status;
  assign out_result_id     = ores_r.id;
  assign out_fired         = ores_r.fired;
  assign out_last          = olast_r;
  assign out_next_delay    = ond_r;
  assign out_target_exists = oex_r;
  assign out_active_count  = ocnt_r;

`ifndef SYNTHESIS
  // valid bits and list length move together
  a_len_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == 32'(len_r))
    else $error("list length disagrees with valid bits");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(len_r) <= TIMER_SLOTS)
    else $error("list length beyond slot count");

  a_fire_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(n_r) <= mtq_pkg::FIRE_LIMIT)
    else $error("result buffer overrun");

  // a request is only taken once the last result of the previous one is in the output register
  a_accept_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && ov_r) |-> olast_r)
    else $error("request accepted while results pending");
`endif

endmodule
